### design/pcd_pkg.sv
// ----------------------------------------------------------------------------
// pcd_pkg
// Shared widths and thresholds for the pixel change detector.
// ----------------------------------------------------------------------------
package pcd_pkg;

   localparam int unsigned FRAC_BITS   = 15;
   localparam int unsigned CHAN_W      = 16;
   localparam int unsigned NUM_COLORS  = 3;
   localparam int unsigned PROD_W      = 2 * CHAN_W;
   localparam int unsigned SUM_W       = PROD_W + 2;
   localparam int unsigned SCALE_SHIFT = 4;
   localparam int unsigned CMP_W       = SUM_W + SCALE_SHIFT;
   localparam int unsigned INC_W       = CHAN_W + 1;

   typedef logic [CHAN_W-1:0]       chan_type;
   typedef logic [PROD_W-1:0]       prod_type;
   typedef logic signed [INC_W-1:0] inc_type;
   typedef logic signed [INC_W:0]   inc2_type;

   // alpha increase limits: one quarter, and one sixty-fourth
   localparam inc_type JUMP_LIM = inc_type'(1) << (FRAC_BITS - 2);
   localparam inc_type REL_LIM  = inc_type'(1) << (FRAC_BITS - 6);

endpackage

### design/pcd_req_if.sv
// ----------------------------------------------------------------------------
// pcd_req_if
// Pixel pair channel: old and new premultiplied RGBA.
// ----------------------------------------------------------------------------
interface pcd_req_if;
   import pcd_pkg::*;

   logic     valid;
   logic     ready;
   chan_type old_red;
   chan_type old_green;
   chan_type old_blue;
   chan_type old_alpha;
   chan_type new_red;
   chan_type new_green;
   chan_type new_blue;
   chan_type new_alpha;

   modport source (
      output valid, old_red, old_green, old_blue, old_alpha,
             new_red, new_green, new_blue, new_alpha,
      input  ready
   );

   modport sink (
      input  valid, old_red, old_green, old_blue, old_alpha,
             new_red, new_green, new_blue, new_alpha,
      output ready
   );

endinterface

### design/pcd_rsp_if.sv
// ----------------------------------------------------------------------------
// pcd_rsp_if
// Change flag channel.
// ----------------------------------------------------------------------------
interface pcd_rsp_if;

   logic valid;
   logic ready;
   logic changed;

   modport source (
      output valid, changed,
      input  ready
   );

   modport sink (
      input  valid, changed,
      output ready
   );

endinterface

### design/pixel_change_detector.sv
// ----------------------------------------------------------------------------
// pixel_change_detector
// Flags a visible change between an old and a new premultiplied RGBA pixel.
//
//   channel   dir  payload
//   req_ch    in   old/new red, green, blue, alpha (16b each, 1.15)
//   rsp_ch    out  changed (1b)
//
// One pixel pair per cycle while the output is not stalled; three register
// stages (input, cross-alpha products, result), and a flag is offered
// from the result register.
// Synchronous reset empties all stages; no other state is kept.
// A stalled output holds the pipe; each stage still fills if empty.
// ----------------------------------------------------------------------------
module pixel_change_detector (
   input logic clock,
   input logic reset,
   pcd_req_if.sink   req_ch,
   pcd_rsp_if.source rsp_ch
);
   import pcd_pkg::*;

   // stage 1: input register
   logic     s1_valid_ff, s1_valid_in;
   chan_type s1_old_col_ff [NUM_COLORS];
   chan_type s1_new_col_ff [NUM_COLORS];
   chan_type s1_old_a_ff;
   chan_type s1_new_a_ff;

   // stage 2: products and alpha tests
   logic     s2_valid_ff, s2_valid_in;
   prod_type s2_prod_new_ff [NUM_COLORS];
   prod_type s2_prod_old_ff [NUM_COLORS];
   chan_type s2_big_a_ff;
   logic     s2_jump_ff, s2_jump_in;

   // stage 3: result register
   logic     s3_valid_ff, s3_valid_in;
   logic     s3_changed_ff, s3_changed_in;

   logic     en1, en2, en3;
   inc_type  inc;
   inc2_type inc2;
   inc2_type old_a_ext;
   prod_type diff [NUM_COLORS];
   logic [SUM_W-1:0] sum;
   logic [CMP_W-1:0] lhs;
   logic [CMP_W-1:0] rhs;

   assign en3 = !s3_valid_ff || rsp_ch.ready;
   assign en2 = !s2_valid_ff || en3;
   assign en1 = !s1_valid_ff || en2;
   assign req_ch.ready = en1;

   assign s1_valid_in = en1 ? req_ch.valid : s1_valid_ff;
   assign s2_valid_in = en2 ? s1_valid_ff  : s2_valid_ff;
   assign s3_valid_in = en3 ? s2_valid_ff  : s3_valid_ff;

   // alpha increase tests
   always_comb begin
      inc       = inc_type'({1'b0, s1_new_a_ff}) - inc_type'({1'b0, s1_old_a_ff});
      inc2      = {inc, 1'b0};
      old_a_ext = inc2_type'({2'b00, s1_old_a_ff});
      s2_jump_in = (inc > JUMP_LIM) || ((inc > REL_LIM) && (inc2 > old_a_ext));
   end

   // color distance on the common alpha scale
   always_comb begin
      sum = '0;
      for (int c = 0; c < NUM_COLORS; c++) begin
         diff[c] = (s2_prod_new_ff[c] > s2_prod_old_ff[c]) ?
                   (s2_prod_new_ff[c] - s2_prod_old_ff[c]) :
                   (s2_prod_old_ff[c] - s2_prod_new_ff[c]);
         sum = sum + SUM_W'(diff[c]);
      end
      lhs = {sum, {SCALE_SHIFT{1'b0}}};
      rhs = CMP_W'(s2_big_a_ff) << FRAC_BITS;
      s3_changed_in = (lhs > rhs) || s2_jump_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
         s3_valid_ff <= s3_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en1) begin
         s1_old_col_ff[0] <= req_ch.old_red;
         s1_old_col_ff[1] <= req_ch.old_green;
         s1_old_col_ff[2] <= req_ch.old_blue;
         s1_new_col_ff[0] <= req_ch.new_red;
         s1_new_col_ff[1] <= req_ch.new_green;
         s1_new_col_ff[2] <= req_ch.new_blue;
         s1_old_a_ff      <= req_ch.old_alpha;
         s1_new_a_ff      <= req_ch.new_alpha;
      end
      if (en2) begin
         for (int c = 0; c < NUM_COLORS; c++) begin
            s2_prod_new_ff[c] <= PROD_W'(s1_new_col_ff[c]) * PROD_W'(s1_old_a_ff);
            s2_prod_old_ff[c] <= PROD_W'(s1_old_col_ff[c]) * PROD_W'(s1_new_a_ff);
         end
         s2_big_a_ff <= (s1_old_a_ff > s1_new_a_ff) ? s1_old_a_ff : s1_new_a_ff;
         s2_jump_ff  <= s2_jump_in;
      end
      if (en3) begin
         s3_changed_ff <= s3_changed_in;
      end
   end

   assign rsp_ch.valid   = s3_valid_ff;
   assign rsp_ch.changed = s3_changed_ff;

`ifndef NO_ASSERTIONS
   a_reset_empties: assert property (@(posedge clock)
      reset |=> (!s1_valid_ff && !s2_valid_ff && !s3_valid_ff))
      else $error("pipeline not empty after reset");

   a_accept_fills: assert property (@(posedge clock) disable iff (reset)
      (req_ch.valid && req_ch.ready) |=> s1_valid_ff)
      else $error("accepted pixel pair lost at stage 1");

   a_jump_flags: assert property (@(posedge clock) disable iff (reset)
      (s2_valid_ff && en3 && s2_jump_ff) |=> (rsp_ch.valid && rsp_ch.changed))
      else $error("alpha jump did not set the change flag");

   a_full_blocks: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && s2_valid_ff && s3_valid_ff && !rsp_ch.ready) |-> !req_ch.ready)
      else $error("input taken while pipeline full and stalled");
`endif

endmodule

### bench/tb_pixel_change_detector.sv
// ----------------------------------------------------------------------------
// tb_pixel_change_detector
// Self-checking bench for the pixel change detector. Pixel pairs go in
// through the request channel with random gaps. A scoreboard predicts each
// change flag from the pixel pair that was transferred and compares it with
// the flag that comes out. The result side stalls at random, and once for a
// long stretch so that the pipe fills and backs up into the input.
// ----------------------------------------------------------------------------
module tb_pixel_change_detector;
   timeunit 1ns;
   timeprecision 1ps;

   import pcd_pkg::*;

   typedef struct packed {
      chan_type old_red;
      chan_type old_green;
      chan_type old_blue;
      chan_type old_alpha;
      chan_type new_red;
      chan_type new_green;
      chan_type new_blue;
      chan_type new_alpha;
   } pixel_pair_type;

   typedef struct packed {
      pixel_pair_type pix;
      logic           flag;
   } pending_flag_type;

   class change_scoreboard;
      pending_flag_type pending_flags[$];
      int unsigned      errors;
      int unsigned      pairs_seen;
      int unsigned      flags_checked;
      int unsigned      flags_set;

      function new();
         errors        = 0;
         pairs_seen    = 0;
         flags_checked = 0;
         flags_set     = 0;
      endfunction

      function logic [63:0] cross_diff(chan_type old_c, chan_type new_c,
                                       chan_type old_a, chan_type new_a);
         logic [63:0] lhs;
         logic [63:0] rhs;
         lhs = 64'(new_c) * 64'(old_a);
         rhs = 64'(old_c) * 64'(new_a);
         return (lhs > rhs) ? lhs - rhs : rhs - lhs;
      endfunction

      function logic predict_changed(pixel_pair_type p);
         logic [63:0] diff_sum;
         logic [63:0] big_alpha;
         longint      alpha_inc;
         logic        color_hit;
         logic        jump_hit;
         logic        rel_hit;
         diff_sum = cross_diff(p.old_red, p.new_red, p.old_alpha, p.new_alpha)
                  + cross_diff(p.old_green, p.new_green, p.old_alpha, p.new_alpha)
                  + cross_diff(p.old_blue, p.new_blue, p.old_alpha, p.new_alpha);
         big_alpha = (p.old_alpha > p.new_alpha) ? 64'(p.old_alpha) : 64'(p.new_alpha);
         color_hit = (diff_sum << 4) > (big_alpha << FRAC_BITS);
         alpha_inc = longint'(p.new_alpha) - longint'(p.old_alpha);
         jump_hit  = alpha_inc > (longint'(1) << (FRAC_BITS - 2));
         rel_hit   = (alpha_inc > (longint'(1) << (FRAC_BITS - 6)))
                     && (alpha_inc * 2 > longint'(p.old_alpha));
         return color_hit | jump_hit | rel_hit;
      endfunction

      task report(string msg);
         $display("[%0t] mismatch: %s", $realtime, msg);
         errors++;
      endtask

      task note_pair(pixel_pair_type p);
         pending_flag_type entry;
         entry.pix  = p;
         entry.flag = predict_changed(p);
         pending_flags.push_back(entry);
         pairs_seen++;
      endtask

      task check_flag(logic got);
         pending_flag_type entry;
         flags_checked++;
         if (pending_flags.size() == 0) begin
            report($sformatf("flag %b with no pixel pair pending", got));
         end else begin
            entry = pending_flags.pop_front();
            if (entry.flag) flags_set++;
            if (got !== entry.flag)
               report($sformatf("changed %b, want %b, old %0d/%0d/%0d/%0d new %0d/%0d/%0d/%0d",
                  got, entry.flag, entry.pix.old_red, entry.pix.old_green,
                  entry.pix.old_blue, entry.pix.old_alpha, entry.pix.new_red,
                  entry.pix.new_green, entry.pix.new_blue, entry.pix.new_alpha));
         end
      endtask
   endclass

   logic clock;
   logic reset;

   pcd_req_if req_ch();
   pcd_rsp_if rsp_ch();

   pixel_change_detector dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   change_scoreboard sb = new();
   bit send_burst = 0;
   bit recv_burst = 0;
   bit long_hold_done = 0;

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   initial begin
      #5_000_000;
      $display("simulation failed");
      $finish;
   end

   function automatic chan_type clip16(int r);
      if (r < 0) r = 0;
      if (r > 65535) r = 65535;
      return chan_type'(r);
   endfunction

   function automatic chan_type nudge(chan_type v, int span);
      return clip16(int'(v) + int'($urandom_range(0, 2 * span)) - span);
   endfunction

   function automatic pixel_pair_type make_pair(int o_r, int o_g, int o_b, int o_a,
                                                int n_r, int n_g, int n_b, int n_a);
      pixel_pair_type p;
      p.old_red   = chan_type'(o_r);
      p.old_green = chan_type'(o_g);
      p.old_blue  = chan_type'(o_b);
      p.old_alpha = chan_type'(o_a);
      p.new_red   = chan_type'(n_r);
      p.new_green = chan_type'(n_g);
      p.new_blue  = chan_type'(n_b);
      p.new_alpha = chan_type'(n_a);
      return p;
   endfunction

   function automatic pixel_pair_type random_pair();
      pixel_pair_type p;
      int unsigned    pick;
      int             oa;
      int             inc;
      pick = $urandom_range(0, 99);
      if (pick < 15) begin
         // raw 16-bit noise
         p = pixel_pair_type'({$urandom, $urandom, $urandom, $urandom});
      end else if (pick < 40) begin
         p = make_pair($urandom_range(0, 32768), $urandom_range(0, 32768),
                       $urandom_range(0, 32768), $urandom_range(0, 32768),
                       $urandom_range(0, 32768), $urandom_range(0, 32768),
                       $urandom_range(0, 32768), $urandom_range(0, 32768));
      end else if (pick < 85) begin
         // small stroke on a premultiplied pixel
         p.old_alpha = chan_type'($urandom_range(0, 32768));
         p.old_red   = chan_type'($urandom_range(0, p.old_alpha));
         p.old_green = chan_type'($urandom_range(0, p.old_alpha));
         p.old_blue  = chan_type'($urandom_range(0, p.old_alpha));
         p.new_alpha = nudge(p.old_alpha, 600);
         p.new_red   = nudge(p.old_red, 1200);
         p.new_green = nudge(p.old_green, 1200);
         p.new_blue  = nudge(p.old_blue, 1200);
      end else begin
         // alpha increase near the jump limits
         oa = $urandom_range(0, 40000);
         case ($urandom_range(0, 5))
            0: inc = 512;
            1: inc = 513;
            2: inc = 8192;
            3: inc = 8193;
            4: inc = oa / 2;
            default: inc = oa / 2 + 1;
         endcase
         p.old_alpha = chan_type'(oa);
         p.new_alpha = clip16(oa + inc);
         if ($urandom_range(0, 1) == 0) begin
            p.old_red = '0; p.old_green = '0; p.old_blue = '0;
            p.new_red = '0; p.new_green = '0; p.new_blue = '0;
         end else begin
            p.old_red   = chan_type'($urandom_range(0, 32768));
            p.old_green = chan_type'($urandom_range(0, 32768));
            p.old_blue  = chan_type'($urandom_range(0, 32768));
            p.new_red   = chan_type'($urandom_range(0, 32768));
            p.new_green = chan_type'($urandom_range(0, 32768));
            p.new_blue  = chan_type'($urandom_range(0, 32768));
         end
      end
      return p;
   endfunction

   task automatic drive_pair(pixel_pair_type p);
      req_ch.old_red   <= p.old_red;
      req_ch.old_green <= p.old_green;
      req_ch.old_blue  <= p.old_blue;
      req_ch.old_alpha <= p.old_alpha;
      req_ch.new_red   <= p.new_red;
      req_ch.new_green <= p.new_green;
      req_ch.new_blue  <= p.new_blue;
      req_ch.new_alpha <= p.new_alpha;
   endtask

   task automatic send_pair(pixel_pair_type p);
      int unsigned gap;
      if ($urandom_range(0, 49) == 0) send_burst = !send_burst;
      gap = send_burst ? 0 : $urandom_range(0, 14);
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      drive_pair(p);
      req_ch.valid <= 1'b1;
      do @(posedge clock); while (req_ch.ready !== 1'b1);
      sb.note_pair(p);
   endtask

   task automatic run_directed();
      send_pair(make_pair(0, 0, 0, 0, 0, 0, 0, 0));
      send_pair(make_pair(32768, 32768, 32768, 32768, 32768, 32768, 32768, 32768));
      send_pair(make_pair(65535, 65535, 65535, 65535, 65535, 65535, 65535, 65535));
      send_pair(make_pair(0, 0, 0, 0, 32768, 32768, 32768, 32768));
      // both alphas zero
      send_pair(make_pair(65535, 0, 65535, 0, 0, 65535, 0, 0));
      // alpha decrease, same and then different color on the common scale
      send_pair(make_pair(16384, 16384, 16384, 32768, 8192, 8192, 8192, 16384));
      send_pair(make_pair(0, 0, 0, 32768, 16384, 0, 0, 16384));
      // alpha jump edge
      send_pair(make_pair(0, 0, 0, 20000, 0, 0, 0, 28192));
      send_pair(make_pair(0, 0, 0, 20000, 0, 0, 0, 28193));
      // relative jump edges
      send_pair(make_pair(0, 0, 0, 1026, 0, 0, 0, 1539));
      send_pair(make_pair(0, 0, 0, 1025, 0, 0, 0, 1538));
      send_pair(make_pair(0, 0, 0, 0, 0, 0, 0, 512));
      send_pair(make_pair(0, 0, 0, 0, 0, 0, 0, 513));
      // color sum edge
      send_pair(make_pair(10000, 0, 0, 32768, 12048, 0, 0, 32768));
      send_pair(make_pair(10000, 5000, 3000, 32768, 11000, 6000, 2951, 32768));
      // values above one, then a one-LSB alpha increase
      send_pair(make_pair(40000, 50000, 65535, 65535, 40000, 50000, 65535, 65535));
      send_pair(make_pair(0, 0, 0, 40000, 0, 0, 0, 65535));
      send_pair(make_pair(65535, 0, 65535, 65535, 65535, 65535, 0, 65535));
      send_pair(make_pair(0, 0, 0, 65535, 0, 0, 0, 0));
      send_pair(make_pair(1, 1, 1, 1, 1, 1, 1, 2));
   endtask

   // result side
   initial begin
      int unsigned gap;
      rsp_ch.ready <= 1'b0;
      @(posedge clock);
      while (reset !== 1'b0) @(posedge clock);
      forever begin
         if ($urandom_range(0, 49) == 0) recv_burst = !recv_burst;
         gap = recv_burst ? 0 : $urandom_range(0, 14);
         if (!long_hold_done && sb.flags_checked == 600) begin
            long_hold_done = 1;
            gap = 300;
         end
         if (gap > 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_ch.ready <= 1'b1;
         do @(posedge clock); while (rsp_ch.valid !== 1'b1);
         sb.check_flag(rsp_ch.changed);
      end
   end

   // request side and run control
   initial begin
      reset        <= 1'b1;
      req_ch.valid <= 1'b0;
      drive_pair('0);
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      run_directed();
      repeat (1850) send_pair(random_pair());
      req_ch.valid <= 1'b0;
      while (sb.pending_flags.size() != 0) @(posedge clock);
      repeat (12) @(posedge clock);
      $display("%0d pixel pairs transferred, %0d flags checked, %0d of them set",
               sb.pairs_seen, sb.flags_checked, sb.flags_set);
      $display("covered corners, threshold edges, small strokes, 16-bit noise, long output stall");
      if (sb.errors == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
